/* hdl/rrs_pkg.sv */
// rrs_pkg: constants, record entry type and status codes of the record rank sorter
// no dependencies
`default_nettype none

package rrs_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ID_W    = 20;
   localparam int SCORE_W = 7;
   localparam int TOTAL_W = 9;
   localparam int RANK_W  = 4;
   localparam int STAT_W  = 3;

   localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;

   localparam logic [STAT_W-1:0] ST_RANKED    = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_SCORE = 3'd1;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] math;
      logic [SCORE_W-1:0] physics;
      logic [SCORE_W-1:0] english;
      logic [TOTAL_W-1:0] total;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

/* hdl/rrs_ram.sv */
// rrs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/record_rank_sorter.sv */
// record_rank_sorter: record table with duplicate check, stable descending sort and read-out
// depends on rrs_pkg and rrs_ram
//
//   channel   ports                    transfer
//   request   start, busy, req_*       start high and busy low at a rising edge
//   response  rsp_valid, rsp_*         every cycle with rsp_valid high, no stall
//
// a record with a bad score is rejected right after the check; one with stored records first
// goes through the id scan (it walks the table ram through its one read port, entry by entry)
// the final item then leads to the sort, pass after pass of shrinking length on the one
// comparator, then to the read-out, one result per cycle
// reset is synchronous and empties the table; the table ram itself is not cleared
// results cannot be stalled; busy falls in the cycle that carries the last result
`default_nettype none

module record_rank_sorter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [19:0] req_student_id,
   input  wire logic [6:0]  req_math_score,
   input  wire logic [6:0]  req_physics_score,
   input  wire logic [6:0]  req_english_score,
   input  wire logic        req_final_record,
   output logic             rsp_valid,
   output logic [19:0]      rsp_out_id,
   output logic [6:0]       rsp_out_math,
   output logic [6:0]       rsp_out_physics,
   output logic [6:0]       rsp_out_english,
   output logic [8:0]       rsp_total_score,
   output logic [3:0]       rsp_rank_position,
   output logic [2:0]       rsp_result_status,
   output logic             rsp_last_of_run
);

   localparam int IW = rrs_pkg::IDX_W;
   localparam int CW = rrs_pkg::CNT_W;
   localparam int TW = rrs_pkg::TOTAL_W;
   localparam int RW = rrs_pkg::RANK_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_DUP_RD   = 4'd2;
   localparam logic [3:0] S_DUP_CMP  = 4'd3;
   localparam logic [3:0] S_REJECT   = 4'd4;
   localparam logic [3:0] S_STORE    = 4'd5;
   localparam logic [3:0] S_FINAL    = 4'd6;
   localparam logic [3:0] S_SORT_LD  = 4'd7;
   localparam logic [3:0] S_SORT_CUR = 4'd8;
   localparam logic [3:0] S_SORT_CMP = 4'd9;
   localparam logic [3:0] S_SORT_END = 4'd10;
   localparam logic [3:0] S_EMIT_RD  = 4'd11;
   localparam logic [3:0] S_EMIT_OUT = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] pass_end_ff, pass_end_in;
   logic [IW-1:0] emit_ff, emit_in;
   logic [RW-1:0] rank_ff, rank_in;
   logic [2:0]    status_ff, status_in;

   rrs_pkg::entry_type cur_ff, cur_in;

   logic [19:0] id_ff;
   logic [6:0]  math_ff, physics_ff, english_ff;
   logic        final_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_id_ff, rsp_id_in;
   logic [6:0]  rsp_math_ff, rsp_math_in;
   logic [6:0]  rsp_physics_ff, rsp_physics_in;
   logic [6:0]  rsp_english_ff, rsp_english_in;
   logic [8:0]  rsp_total_ff, rsp_total_in;
   logic [3:0]  rsp_rank_ff, rsp_rank_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                            wr_en;
   logic [IW-1:0]                   wr_addr;
   rrs_pkg::entry_type              wr_data;
   logic [IW-1:0]                   rd_addr;
   logic [rrs_pkg::ENTRY_W-1:0]     rd_raw;
   rrs_pkg::entry_type              rd_entry;
   logic                            accept;
   logic                            bad_score;
   logic                            emit_last;

   assign rd_entry  = rrs_pkg::entry_type'(rd_raw);
   assign accept    = start && (state_ff == S_IDLE);
   assign bad_score = (math_ff > rrs_pkg::SCORE_MAX) || (physics_ff > rrs_pkg::SCORE_MAX) ||
                      (english_ff > rrs_pkg::SCORE_MAX);
   assign emit_last = (CW'(emit_ff) + CW'(1)) == count_ff;

   rrs_ram #(
      .WIDTH(rrs_pkg::ENTRY_W),
      .DEPTH(rrs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      j_in        = j_ff;
      pass_end_in = pass_end_ff;
      emit_in     = emit_ff;
      rank_in     = rank_ff;
      status_in   = status_ff;
      cur_in      = cur_ff;

      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = cur_ff;
      rd_addr = '0;

      rsp_valid_in   = 1'b0;
      rsp_id_in      = '0;
      rsp_math_in    = '0;
      rsp_physics_in = '0;
      rsp_english_in = '0;
      rsp_total_in   = '0;
      rsp_rank_in    = '0;
      rsp_status_in  = rrs_pkg::ST_RANKED;
      rsp_last_in    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            scan_in = '0;
            if (bad_score) begin
               status_in = rrs_pkg::ST_BAD_SCORE;
               state_in  = S_REJECT;
            end else if (count_ff == '0) begin
               state_in = S_STORE;
            end else begin
               state_in = S_DUP_RD;
            end
         end
         S_DUP_RD: begin
            rd_addr  = scan_ff;
            state_in = S_DUP_CMP;
         end
         S_DUP_CMP: begin
            if (rd_entry.id == id_ff) begin
               status_in = rrs_pkg::ST_DUPLICATE;
               state_in  = S_REJECT;
            end else if ((CW'(scan_ff) + CW'(1)) == count_ff) begin
               if (count_ff >= CW'(rrs_pkg::TABLE_DEPTH)) begin
                  status_in = rrs_pkg::ST_FULL;
                  state_in  = S_REJECT;
               end else begin
                  state_in = S_STORE;
               end
            end else begin
               scan_in  = scan_ff + IW'(1);
               state_in = S_DUP_RD;
            end
         end
         S_REJECT: begin
            rsp_valid_in   = 1'b1;
            rsp_id_in      = id_ff;
            rsp_math_in    = math_ff;
            rsp_physics_in = physics_ff;
            rsp_english_in = english_ff;
            rsp_status_in  = status_ff;
            rsp_last_in    = !final_ff;
            state_in       = final_ff ? S_FINAL : S_IDLE;
         end
         S_STORE: begin
            wr_en           = 1'b1;
            wr_addr         = count_ff[IW-1:0];
            wr_data.id      = id_ff;
            wr_data.math    = math_ff;
            wr_data.physics = physics_ff;
            wr_data.english = english_ff;
            wr_data.total   = TW'(math_ff) + TW'(physics_ff) + TW'(english_ff);
            count_in        = count_ff + CW'(1);
            state_in        = final_ff ? S_FINAL : S_IDLE;
         end
         S_FINAL: begin
            emit_in = '0;
            rank_in = '0;
            if (count_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = rrs_pkg::ST_EMPTY;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else if (count_ff == CW'(1)) begin
               state_in = S_EMIT_RD;
            end else begin
               pass_end_in = IW'(count_ff - CW'(1));
               state_in    = S_SORT_LD;
            end
         end
         S_SORT_LD: begin
            rd_addr  = '0;
            j_in     = '0;
            state_in = S_SORT_CUR;
         end
         S_SORT_CUR: begin
            cur_in   = rd_entry;
            rd_addr  = IW'(1);
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            rd_addr = j_ff + IW'(2);
            wr_en   = 1'b1;
            wr_addr = j_ff;
            // strict compare keeps equal totals in load order
            if (cur_ff.total < rd_entry.total) begin
               wr_data = rd_entry;
            end else begin
               wr_data = cur_ff;
               cur_in  = rd_entry;
            end
            if ((j_ff + IW'(1)) == pass_end_ff) begin
               state_in = S_SORT_END;
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         S_SORT_END: begin
            wr_en       = 1'b1;
            wr_addr     = pass_end_ff;
            wr_data     = cur_ff;
            pass_end_in = pass_end_ff - IW'(1);
            state_in    = (pass_end_ff == IW'(1)) ? S_EMIT_RD : S_SORT_LD;
         end
         S_EMIT_RD: begin
            rd_addr  = emit_ff;
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            rd_addr        = emit_ff + IW'(1);
            rsp_valid_in   = 1'b1;
            rsp_id_in      = rd_entry.id;
            rsp_math_in    = rd_entry.math;
            rsp_physics_in = rd_entry.physics;
            rsp_english_in = rd_entry.english;
            rsp_total_in   = rd_entry.total;
            rsp_rank_in    = rank_ff;
            rsp_status_in  = rrs_pkg::ST_RANKED;
            rsp_last_in    = emit_last;
            emit_in        = emit_ff + IW'(1);
            rank_in        = rank_ff + RW'(1);
            if (emit_last) begin
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      j_ff        <= j_in;
      pass_end_ff <= pass_end_in;
      emit_ff     <= emit_in;
      rank_ff     <= rank_in;
      status_ff   <= status_in;
      cur_ff      <= cur_in;

      rsp_id_ff      <= rsp_id_in;
      rsp_math_ff    <= rsp_math_in;
      rsp_physics_ff <= rsp_physics_in;
      rsp_english_ff <= rsp_english_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_rank_ff    <= rsp_rank_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;

      if (accept) begin
         id_ff      <= req_student_id;
         math_ff    <= req_math_score;
         physics_ff <= req_physics_score;
         english_ff <= req_english_score;
         final_ff   <= req_final_record;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_out_math      = rsp_math_ff;
   assign rsp_out_physics   = rsp_physics_ff;
   assign rsp_out_english   = rsp_english_ff;
   assign rsp_total_score   = rsp_total_ff;
   assign rsp_rank_position = rsp_rank_ff;
   assign rsp_result_status = rsp_status_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // accepted request keeps the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   // table fill never exceeds its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(rrs_pkg::TABLE_DEPTH))
      else $error("stored count above table depth");

   // ranked result carries the sum of its scores
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_status == rrs_pkg::ST_RANKED)) |->
      (rsp_total_score == (TW'(rsp_out_math) + TW'(rsp_out_physics) + TW'(rsp_out_english))))
      else $error("ranked total does not match scores");

   // end of a run leaves an empty table
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run && ((rsp_result_status == rrs_pkg::ST_RANKED) ||
       (rsp_result_status == rrs_pkg::ST_EMPTY))) |-> (count_ff == '0))
      else $error("table not emptied after read-out");

   // no result right after the last result of an item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |=> !rsp_valid)
      else $error("result issued right after last of run");

endmodule

`default_nettype wire
